>>> rtl/fot_pkg.sv
// Shared types and constants for the fork ownership table.
package fot_pkg;

	localparam int NUM_FORKS = 1024;
	localparam int IDX_W     = $clog2(NUM_FORKS);
	localparam int Q_DEPTH   = 4;
	localparam int QP_W      = $clog2(Q_DEPTH);
	localparam int QC_W      = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] FUNC_INIT    = 2'd0;
	localparam logic [1:0] FUNC_ACQUIRE = 2'd1;
	localparam logic [1:0] FUNC_STOP    = 2'd2;
	localparam logic [1:0] FUNC_UNLOCK  = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [9:0] edge_index;
		logic       side;
		logic       init_owner;
	} cmd_t;

	typedef struct packed {
		logic granted;
		logic owner_now;
		logic dirty_now;
		logic locked_now;
		logic requested_now;
	} result_t;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ACQUIRE = 2'd1,
		OP_STOP    = 2'd2,
		OP_UNLOCK  = 2'd3
	} op_t;

	// one decoded item as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic             side;
		logic             init_owner;
	} item_t;

	typedef struct packed {
		logic owner;
		logic dirty;
		logic locked;
		logic requested;
	} flags_t;

endpackage

>>> rtl/fot_front.sv
// Front end: takes command beats, decodes them and queues them for the back end.
module fot_front import fot_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  cmd_t  cmd,
	output logic  busy,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	item_t           queue_q [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;
	logic            push;
	logic            do_pop;
	item_t           dec;

	always_comb begin
		unique case (cmd.func)
			FUNC_INIT:    dec.op = OP_INIT;
			FUNC_ACQUIRE: dec.op = OP_ACQUIRE;
			FUNC_STOP:    dec.op = OP_STOP;
			FUNC_UNLOCK:  dec.op = OP_UNLOCK;
			default:      dec.op = OP_INIT;
		endcase
		// table index wraps modulo the table size
		dec.idx        = cmd.edge_index[IDX_W-1:0];
		dec.side       = cmd.side;
		dec.init_owner = cmd.init_owner;
	end

	assign busy       = (count_q == QC_W'(Q_DEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/fot_back.sv
// Back end: flag table memory, read-modify-write and result register.
module fot_back import fot_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  item_t   head,
	output logic    pop,
	output logic    done,
	output result_t result
);

	flags_t  mem [NUM_FORKS];
	flags_t  rd_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    fwd_s1;
	flags_t  fwd_q;
	flags_t  cur;
	flags_t  nxt;
	logic    grant;
	result_t result_q;
	logic    done_q;

	// back end never stalls: take a beat whenever one is queued
	assign pop = head_valid;

	assign cur = fwd_s1 ? fwd_q : rd_q;

	always_comb begin
		nxt   = cur;
		grant = 1'b0;
		unique case (item_s1.op)
			OP_INIT: begin
				nxt = '{owner: item_s1.init_owner, dirty: 1'b1, locked: 1'b0,
					requested: 1'b0};
			end
			OP_ACQUIRE: begin
				if (cur.owner == item_s1.side) begin
					nxt.locked = 1'b1;
				end else if (cur.dirty && !cur.locked) begin
					nxt = '{owner: item_s1.side, dirty: 1'b0, locked: 1'b1,
						requested: 1'b0};
				end else begin
					nxt.requested = 1'b1;
				end
				grant = (nxt.owner == item_s1.side) && nxt.locked;
			end
			OP_STOP: begin
				nxt.locked = 1'b0;
				nxt.dirty  = 1'b1;
				if (cur.requested) begin
					nxt.owner     = !cur.owner;
					nxt.dirty     = 1'b0;
					nxt.requested = 1'b0;
				end
			end
			OP_UNLOCK: begin
				if (cur.owner == item_s1.side && cur.locked) begin
					nxt.locked = 1'b0;
				end
				if (cur.owner == item_s1.side && cur.dirty && cur.requested) begin
					nxt.owner = !cur.owner;
					nxt.dirty = 1'b0;
				end
			end
			default: nxt = cur;
		endcase
	end

	// table: read for the popped beat, write back the finished one
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= mem[head.idx];
		end
		if (valid_s1) begin
			mem[item_s1.idx] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
			fwd_q   <= nxt;
		end
		if (valid_s1) begin
			result_q <= '{granted: grant, owner_now: nxt.owner, dirty_now: nxt.dirty,
				locked_now: nxt.locked, requested_now: nxt.requested};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= pop;
			// back-to-back beats on the same entry: the read sees the old value
			fwd_s1   <= pop && valid_s1 && (head.idx == item_s1.idx);
			done_q   <= valid_s1;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1))
		else $error("result strobe without a beat in flight");

	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarding flag without a beat in stage 1");

	a_grant_locked: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.granted |-> result_q.locked_now)
		else $error("grant reported on an unlocked fork");

	a_grant_acquire: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.op != OP_ACQUIRE |=> !result_q.granted)
		else $error("grant reported for an operation other than acquire");
`endif

endmodule

>>> rtl/fork_ownership_table_top.sv
// Top level of the fork ownership table: front end, queue and back end.
// Each command beat is taken when start is high and busy is low; one item may
// be taken every cycle. Its result appears on result, marked by done for one
// cycle, once the beat has been written into the command queue, popped from it
// with the table read registered, and had the flag update applied with the
// result register loaded; the receiver cannot hold it off.
// The back end pops a queued beat on every cycle, so the four-deep command
// queue never holds more than one beat and busy stays low. The 1024-entry flag
// table is not cleared at reset: every entry must be written by an init command
// before any other command addresses it. An edge index wraps modulo the table size.
module fork_ownership_table_top import fot_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	logic  pop;
	logic  head_valid;
	item_t head;

	fot_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fot_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.result     (result)
	);

endmodule

>>> tb/fork_ownership_table_top_test.sv
// Self-checking testbench for the fork ownership table: random and directed fork commands.
`timescale 1ns / 1ps

module fork_ownership_table_top_test;
	import fot_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int RANDOM_CMDS = 1700;
	localparam int HOT_EDGES   = 8;

	typedef struct packed {
		cmd_t c;
		logic drain;	// hold off until every report has come back
	} backlog_entry_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	backlog_entry_t cmd_backlog[$];
	result_t        reports_due[$];
	flags_t         fork_shadow[NUM_FORKS];
	bit             edge_ready[NUM_FORKS];	// generator side: init already queued

	int mismatch_count = 0;
	int reports_checked = 0;
	int grants_seen = 0;
	int op_seen[4] = '{0, 0, 0, 0};
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;

	logic took;
	logic next_start;
	cmd_t next_cmd;

	fork_ownership_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// fork flag update for one command; returns the report the block should give
	function automatic result_t apply_fork_op(cmd_t c);
		flags_t  f;
		result_t r;
		logic    own;
		f = fork_shadow[c.edge_index];
		r = '0;
		own = (f.owner == c.side);
		case (op_t'(c.func))
			OP_INIT: begin
				f.owner = c.init_owner;
				f.dirty = 1'b1;
				f.locked = 1'b0;
				f.requested = 1'b0;
			end
			OP_ACQUIRE: begin
				if (own) begin
					f.locked = 1'b1;
				end else if (f.dirty && !f.locked) begin
					f.owner = c.side;
					f.dirty = 1'b0;
					f.requested = 1'b0;
					f.locked = 1'b1;
				end else begin
					f.requested = 1'b1;
				end
				r.granted = (f.owner == c.side) && f.locked;
			end
			OP_STOP: begin
				f.locked = 1'b0;
				f.dirty = 1'b1;
				if (f.requested) begin
					f.owner = ~f.owner;
					f.dirty = 1'b0;
					f.requested = 1'b0;
				end
			end
			default: begin
				if (own && f.locked)
					f.locked = 1'b0;
				if (own && f.dirty && f.requested) begin
					f.owner = ~f.owner;
					f.dirty = 1'b0;
				end
			end
		endcase
		fork_shadow[c.edge_index] = f;
		r.owner_now = f.owner;
		r.dirty_now = f.dirty;
		r.locked_now = f.locked;
		r.requested_now = f.requested;
		return r;
	endfunction

	task automatic queue_cmd(op_t op, int idx, bit side, bit owner, bit drain);
		backlog_entry_t e;
		e.c.func = op;
		e.c.edge_index = idx[9:0];
		e.c.side = side;
		e.c.init_owner = owner;
		e.drain = drain;
		if (op == OP_INIT)
			edge_ready[idx] = 1'b1;
		cmd_backlog.push_back(e);
	endtask

	task automatic check_field(string name, logic exp_v, logic act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// driver: bursts of beats with random gaps; a presented beat is held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				reports_due.push_back(apply_fork_op(cmd));
				op_seen[cmd.func]++;
				void'(cmd_backlog.pop_front());
				if (burst_left > 0)
					burst_left--;
			end
			if (start && !took) begin
				next_start = 1'b1;
				next_cmd = cmd;
			end else begin
				next_start = 1'b0;
				next_cmd = cmd_t'($urandom);
				if (gap_left > 0) begin
					gap_left--;
				end else if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				// a report retiring on this edge still counts as outstanding
				if (gap_left == 0 && burst_left > 0 && cmd_backlog.size() != 0 &&
						!(cmd_backlog[0].drain && (reports_due.size() != 0 || done))) begin
					next_start = 1'b1;
					next_cmd = cmd_backlog[0].c;
				end
			end
			start <= next_start;
			cmd <= next_cmd;
		end
	end

	// monitor: every done beat is checked against the oldest outstanding report
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual %b", $time, result);
				mismatch_count++;
			end else begin
				result_t want;
				want = reports_due.pop_front();
				check_field("granted", want.granted, result.granted);
				check_field("owner_now", want.owner_now, result.owner_now);
				check_field("dirty_now", want.dirty_now, result.dirty_now);
				check_field("locked_now", want.locked_now, result.locked_now);
				check_field("requested_now", want.requested_now, result.requested_now);
				reports_checked++;
				if (result.granted)
					grants_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d reports outstanding",
					$time, IDLE_LIMIT, reports_due.size());
				$display("fork_ownership_table_top_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int hot[HOT_EDGES];
		int idx;
		int pick;
		op_t op;

		// directed: grant, request, hand-over on stop and on unlock, take of a dirty fork
		queue_cmd(OP_INIT, 0, 1'b1, 1'b0, 1'b0);
		queue_cmd(OP_ACQUIRE, 0, 1'b0, 1'b1, 1'b0);	// owner locks
		queue_cmd(OP_ACQUIRE, 0, 1'b1, 1'b0, 1'b0);	// locked elsewhere: request
		queue_cmd(OP_UNLOCK, 0, 1'b1, 1'b0, 1'b0);	// not the owner: no change
		queue_cmd(OP_UNLOCK, 0, 1'b0, 1'b0, 1'b0);	// unlock, dirty+requested hands over
		queue_cmd(OP_ACQUIRE, 0, 1'b1, 1'b0, 1'b0);
		queue_cmd(OP_STOP, 0, 1'b0, 1'b1, 1'b0);	// requested: goes back clean
		queue_cmd(OP_ACQUIRE, 0, 1'b1, 1'b0, 1'b0);	// clean, not owned: request
		queue_cmd(OP_ACQUIRE, 0, 1'b0, 1'b0, 1'b0);
		queue_cmd(OP_STOP, 0, 1'b1, 1'b0, 1'b0);
		queue_cmd(OP_ACQUIRE, 0, 1'b0, 1'b1, 1'b0);
		queue_cmd(OP_INIT, 1023, 1'b0, 1'b1, 1'b0);
		queue_cmd(OP_ACQUIRE, 1023, 1'b0, 1'b0, 1'b0);	// dirty and free: taken
		queue_cmd(OP_STOP, 1023, 1'b1, 1'b1, 1'b0);	// no request: stays, dirty
		queue_cmd(OP_UNLOCK, 1023, 1'b0, 1'b1, 1'b0);	// owner, unlocked, no request
		queue_cmd(OP_ACQUIRE, 1023, 1'b1, 1'b0, 1'b0);
		queue_cmd(OP_STOP, 1023, 1'b0, 1'b1, 1'b0);
		queue_cmd(OP_INIT, 1023, 1'b1, 1'b0, 1'b0);	// re-init overwrites
		queue_cmd(OP_UNLOCK, 1023, 1'b0, 1'b1, 1'b0);
		queue_cmd(OP_INIT, 682, 1'b0, 1'b1, 1'b0);
		queue_cmd(OP_ACQUIRE, 682, 1'b1, 1'b0, 1'b0);
		queue_cmd(OP_ACQUIRE, 682, 1'b1, 1'b1, 1'b0);
		queue_cmd(OP_INIT, 341, 1'b1, 1'b1, 1'b0);
		queue_cmd(OP_STOP, 341, 1'b0, 1'b0, 1'b0);

		// random: a few hot edges get most traffic so the flags wander through every state
		hot[0] = 0;
		hot[1] = 1023;
		for (int i = 2; i < HOT_EDGES; i++)
			hot[i] = $urandom_range(0, NUM_FORKS - 1);
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if ($urandom_range(0, 99) < 75)
				idx = hot[$urandom_range(0, HOT_EDGES - 1)];
			else
				idx = $urandom_range(0, NUM_FORKS - 1);
			pick = $urandom_range(0, 99);
			if (!edge_ready[idx] || pick < 8)
				op = OP_INIT;
			else if (pick < 50)
				op = OP_ACQUIRE;
			else if (pick < 78)
				op = OP_STOP;
			else
				op = OP_UNLOCK;
			queue_cmd(op, idx, $urandom_range(0, 1), $urandom_range(0, 1),
				n == 0 || $urandom_range(0, 199) == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || start || reports_due.size() != 0);
		repeat (10) @(posedge clk);

		$display("checked %0d reports: %0d init, %0d acquire, %0d stop, %0d unlock; %0d grants",
			reports_checked, op_seen[OP_INIT], op_seen[OP_ACQUIRE], op_seen[OP_STOP],
			op_seen[OP_UNLOCK], grants_seen);
		if (mismatch_count == 0)
			$display("fork_ownership_table_top_test: done, clean");
		else
			$display("fork_ownership_table_top_test: done, errors");
		$finish;
	end

endmodule
